### src/hamming74_packet_encoder_unit_assert.svh
// Assertion macros shared by the files that carry checks.
// The first form sets the reset disable, the second watches through reset.
`ifndef HAMMING74_PACKET_ENCODER_UNIT_ASSERT_SVH
`define HAMMING74_PACKET_ENCODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define HPE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hpe assertion failed");
`define HPE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hpe assertion failed");
`else
`define HPE_ASSERT(lbl, clk, rst_n, prop)
`define HPE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### src/hpe_pkg.sv
`timescale 1ns / 1ps

package hpe_pkg;

  localparam int IMG_W     = 24;
  localparam int PKT_W     = 16;
  localparam int NIB_CNT_W = 25;
  localparam int CFG_IDX_W = 2;
  localparam int CW_W      = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_IMG_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PKT_LEN = 2'd1;

  localparam logic [IMG_W-1:0] IMG_LEN_RST = 24'd1024;
  localparam logic [PKT_W-1:0] PKT_LEN_RST = 16'd64;

  localparam logic [1:0] KIND_CODEWORD = 2'd0;
  localparam logic [1:0] KIND_HEADER   = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;

  localparam logic [7:0] HEADER_BYTE = 8'h00;
  localparam logic [7:0] END_BYTE    = 8'h01;

  // Both codewords of one input byte, as held in the queue.
  typedef struct packed {
    logic [CW_W-1:0] cw_hi;
    logic [CW_W-1:0] cw_lo;
  } qitem_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic   valid;
    qitem_t item;
  } qhead_t;

  typedef struct packed {
    logic [IMG_W-1:0] img_len;
    logic [PKT_W-1:0] pkt_len;
  } cfg_t;

endpackage

### src/hpe_front.sv
`timescale 1ns / 1ps

module hpe_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                q_pop,
  output hpe_pkg::qhead_t     q_head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Codeword bit p-1 holds position p; parity at positions 1, 2 and 4.
  function automatic logic [hpe_pkg::CW_W-1:0] hamming_cw(input logic [3:0] nib);
    logic p1;
    logic p2;
    logic p4;
    p1 = nib[0] ^ nib[1] ^ nib[3];
    p2 = nib[0] ^ nib[2] ^ nib[3];
    p4 = nib[1] ^ nib[2] ^ nib[3];
    return {nib[3], nib[2], nib[1], p4, nib[0], p2, p1};
  endfunction

  hpe_pkg::qitem_t mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  hpe_pkg::qitem_t  push_item;
  logic             push;

  assign in_ready = (count_r < CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;

  assign push_item.cw_lo = hamming_cw(in_byte[3:0]);
  assign push_item.cw_hi = hamming_cw(in_byte[7:4]);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign q_head.valid = (count_r != '0);
  assign q_head.item  = mem_r[rd_ptr_r];

endmodule

### src/hpe_back.sv
`timescale 1ns / 1ps

module hpe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hpe_pkg::cfg_t        cfg,
  input  hpe_pkg::qhead_t      q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic [1:0]           out_kind,
  output logic                 out_last
);

  typedef enum logic [2:0] {
    MODE_AWAIT  = 3'b001,
    MODE_ENCODE = 3'b010,
    MODE_DONE   = 3'b100
  } mode_t;

  // Where the current byte stands: before its low nibble, after it, or after
  // the high nibble (only seen while a boundary result is pending).
  typedef enum logic [2:0] {
    PH_START    = 3'b001,
    PH_AFTER_LO = 3'b010,
    PH_AFTER_HI = 3'b100
  } phase_t;

  mode_t                          mode_r, mode_nxt;
  phase_t                         phase_r, phase_nxt;
  logic [hpe_pkg::PKT_W-1:0]      pos_r, pos_nxt;
  logic [hpe_pkg::NIB_CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                           out_valid_r;
  logic [7:0]                     out_byte_r;
  logic [1:0]                     out_kind_r;
  logic                           out_last_r;

  logic [7:0]                     emit_byte;
  logic [1:0]                     emit_kind;
  logic                           emit_last;
  logic                           adv;
  logic                           below_limit;
  logic                           pkt_end;
  logic [hpe_pkg::PKT_W-1:0]      pos_inc;
  logic [hpe_pkg::NIB_CNT_W-1:0]  cnt_inc;
  logic [hpe_pkg::CW_W-1:0]       nib_cw;

  assign adv         = q_head.valid && (!out_valid_r || out_ready);
  assign below_limit = (cnt_r < {cfg.img_len, 1'b0});
  assign pos_inc     = pos_r + 1'b1;
  assign pkt_end     = (pos_inc == cfg.pkt_len);
  assign cnt_inc     = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
  assign nib_cw      = (phase_r == PH_START) ? q_head.item.cw_lo : q_head.item.cw_hi;

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    emit_byte = hpe_pkg::END_BYTE;
    emit_kind = hpe_pkg::KIND_END;
    emit_last = 1'b1;
    case (mode_r)
      MODE_ENCODE: begin
        emit_byte = {1'b0, nib_cw};
        emit_kind = hpe_pkg::KIND_CODEWORD;
        emit_last = 1'b0;
        cnt_nxt   = cnt_inc;
        if (pkt_end) begin
          pos_nxt   = '0;
          mode_nxt  = MODE_AWAIT;
          phase_nxt = (phase_r == PH_START) ? PH_AFTER_LO : PH_AFTER_HI;
        end else begin
          pos_nxt = pos_inc;
          if (phase_r == PH_START) begin
            phase_nxt = PH_AFTER_LO;
          end else begin
            emit_last = 1'b1;
            phase_nxt = PH_START;
          end
        end
      end
      MODE_AWAIT: begin
        if (below_limit) begin
          emit_byte = hpe_pkg::HEADER_BYTE;
          emit_kind = hpe_pkg::KIND_HEADER;
          mode_nxt  = MODE_ENCODE;
          if (phase_r == PH_AFTER_HI) begin
            emit_last = 1'b1;
            phase_nxt = PH_START;
          end else begin
            emit_last = 1'b0;
          end
        end else begin
          mode_nxt  = MODE_DONE;
          phase_nxt = PH_START;
        end
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase
  end

  assign q_pop = adv && emit_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_AWAIT;
      phase_r     <= PH_START;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        mode_r      <= mode_nxt;
        phase_r     <= phase_nxt;
        pos_r       <= pos_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= emit_byte;
      out_kind_r <= emit_kind;
      out_last_r <= emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;
  assign out_last  = out_last_r;

endmodule

### src/hamming74_packet_encoder_unit.sv
// A taken beat is written into the front queue; its first result then enters the output register.
// One result per cycle while the queue holds a byte and the output is not stalled. A byte
// yields at most five results, and only an end marker once the stream is done.
// The front queue keeps taking beats while it has room, whatever the output side does.
// Reset is synchronous and active low: control state and queue clear, and the two
// configuration registers return to 1024 bytes and 64 codewords.
`timescale 1ns / 1ps
`include "hamming74_packet_encoder_unit_assert.svh"

module hamming74_packet_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        out_byte,
  output logic [1:0]                        out_kind,
  output logic                              out_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hpe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hpe_pkg::IMG_W-1:0]         cfg_data
);

  // The configuration port never stalls. A write to an index beyond the two
  // registers is taken and dropped. New values must be written only while the block is idle;
  // the block itself does not enforce it. The image length is used at each boundary decision.
  hpe_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        hpe_pkg::CFG_IMG_LEN: cfg_nxt.img_len = cfg_data;
        hpe_pkg::CFG_PKT_LEN: cfg_nxt.pkt_len = cfg_data[hpe_pkg::PKT_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.img_len <= hpe_pkg::IMG_LEN_RST;
      cfg_r.pkt_len <= hpe_pkg::PKT_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end takes a beat, encodes both nibbles at once and queues
  // the pair. The back end owns the packet state: it walks through the
  // header, codeword and end marker results of the byte at the queue head,
  // one result per cycle into the output register while it can take one, and
  // pops the entry with the final result of that byte.
  hpe_pkg::qhead_t q_head;
  logic            q_pop;

  hpe_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  hpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

  logic out_is_cw;
  logic out_is_end;
  logic out_kind_ok;

  assign out_is_cw   = (out_kind == hpe_pkg::KIND_CODEWORD);
  assign out_is_end  = (out_kind == hpe_pkg::KIND_END);
  assign out_kind_ok = out_is_cw || out_is_end || (out_kind == hpe_pkg::KIND_HEADER);

  // A codeword never sets bit 7.
  `HPE_ASSERT(a_cw_msb_clear, clk, rst_n, out_valid && out_is_cw |-> !out_byte[7])
  // Every beat carries one of the three result kinds.
  `HPE_ASSERT(a_kind_legal, clk, rst_n, out_valid |-> out_kind_ok)
  // An end marker always closes its byte.
  `HPE_ASSERT(a_end_is_last, clk, rst_n, out_valid && out_is_end |-> out_last)
  // The back end never pops an empty queue.
  `HPE_ASSERT(a_no_pop_empty, clk, rst_n, q_pop |-> q_head.valid)
  // Reset leaves the queue empty.
  `HPE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !q_head.valid)

endmodule

### tb/sv/hamming74_packet_encoder_unit_test.sv
`timescale 1ns / 1ps

module hamming74_packet_encoder_unit_test;

  // Indexes past the end of the register list. The block must ignore writes to them.
  localparam logic [hpe_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [hpe_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

  // Cycles without any beat on any channel before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  localparam logic [hpe_pkg::NIB_CNT_W-1:0] NIBBLES_SATURATED = '1;

  typedef enum logic [2:0] {
    ST_AWAIT  = 3'b001,
    ST_ENCODE = 3'b010,
    ST_DONE   = 3'b100
  } enc_mode_t;

  // One output beat as the block should produce it.
  typedef struct packed {
    logic [7:0] code;
    logic [1:0] kind;
    logic       last;
  } enc_beat_t;

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_byte   = 8'h00;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [7:0]                    out_byte;
  logic [1:0]                    out_kind;
  logic                          out_last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [hpe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hpe_pkg::IMG_W-1:0]     cfg_data  = '0;

  // Bytes waiting to be offered on the input channel, and the output beats still owed.
  logic [7:0] source_bytes[$];
  enc_beat_t  encoded_stream_q[$];

  // Predicted state of the encoder and its copy of the two registers.
  enc_mode_t                     st_mode    = ST_AWAIT;
  logic [hpe_pkg::PKT_W-1:0]     st_pos     = '0;
  logic [hpe_pkg::NIB_CNT_W-1:0] st_nibbles = '0;
  logic [hpe_pkg::IMG_W-1:0]     cur_image  = hpe_pkg::IMG_LEN_RST;
  logic [hpe_pkg::PKT_W-1:0]     cur_packet = hpe_pkg::PKT_LEN_RST;

  int        fail_count  = 0;
  int        cycle_no    = 0;
  int        quiet_count = 0;
  enc_beat_t seen_want;

  hamming74_packet_encoder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // Parity bits sit at codeword positions 1, 2 and 4; data bits at 3, 5, 6 and 7.
  function automatic logic [hpe_pkg::CW_W-1:0] hamming_cw(input logic [3:0] d);
    logic p1;
    logic p2;
    logic p4;
    p1 = d[0] ^ d[1] ^ d[3];
    p2 = d[0] ^ d[2] ^ d[3];
    p4 = d[1] ^ d[2] ^ d[3];
    return {d[3], d[2], d[1], p4, d[0], p2, p1};
  endfunction

  // At a packet boundary the block either opens a new packet with a header or, once
  // the image is complete, closes the stream with the end marker.
  function automatic void settle_boundary();
    if (st_nibbles < {cur_image, 1'b0}) begin
      encoded_stream_q.push_back('{hpe_pkg::HEADER_BYTE, hpe_pkg::KIND_HEADER, 1'b0});
      st_mode = ST_ENCODE;
    end else begin
      encoded_stream_q.push_back('{hpe_pkg::END_BYTE, hpe_pkg::KIND_END, 1'b0});
      st_mode = ST_DONE;
    end
  endfunction

  // Works out every beat that one accepted byte causes and appends them to the owed list.
  function automatic void encode_step(input logic [7:0] b);
    enc_beat_t  tail;
    logic [3:0] nib;
    int         h;
    if (st_mode == ST_DONE) begin
      encoded_stream_q.push_back('{hpe_pkg::END_BYTE, hpe_pkg::KIND_END, 1'b0});
    end else begin
      // The header still pending after reset is resolved before the low nibble.
      if (st_mode == ST_AWAIT) begin
        settle_boundary();
      end
      // Once the stream ends after the low nibble, the high nibble is dropped.
      for (h = 0; h < 2; h++) begin
        if (st_mode == ST_ENCODE) begin
          nib = (h == 0) ? b[3:0] : b[7:4];
          encoded_stream_q.push_back('{{1'b0, hamming_cw(nib)}, hpe_pkg::KIND_CODEWORD,
                                       1'b0});
          // The position counter wraps, so a packet size of zero or one below the
          // current position gives a packet of up to 65536 codewords.
          st_pos = st_pos + 16'd1;
          if (st_nibbles != NIBBLES_SATURATED) begin
            st_nibbles = st_nibbles + 1'b1;
          end
          if (st_pos == cur_packet) begin
            st_pos  = '0;
            st_mode = ST_AWAIT;
            settle_boundary();
          end
        end
      end
    end
    tail = encoded_stream_q.pop_back();
    tail.last = 1'b1;
    encoded_stream_q.push_back(tail);
  endfunction

  // Random back-off for either side. At regular intervals there is a long calm
  // stretch in which neither side pauses, so back-to-back traffic is exercised too.
  function automatic logic take_break();
    if ((cycle_no % 3000) < 800) begin
      return 1'b0;
    end
    return ($urandom_range(0, 99) < 10);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_no, msg);
    fail_count++;
  endtask

  // Input driver. The byte is predicted at the edge where it is accepted, then the next
  // one is loaded unless the sender takes a random pause. A byte that is not yet taken
  // stays on the port unchanged.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_step(in_byte);
      end
      if (!in_valid || in_ready) begin
        if (source_bytes.size() != 0 && !take_break()) begin
          in_valid <= 1'b1;
          in_byte  <= source_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor. Each accepted beat is compared field by field with the oldest one
  // owed. A beat that arrives while nothing is owed is a failure as well.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (encoded_stream_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat byte=%02h kind=%0d last=%0b",
                                  out_byte, out_kind, out_last));
        end else begin
          seen_want = encoded_stream_q.pop_front();
          if (out_byte !== seen_want.code) begin
            flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte, seen_want.code));
          end
          if (out_kind !== seen_want.kind) begin
            flag_mismatch($sformatf("out_kind %0d, want %0d", out_kind, seen_want.kind));
          end
          if (out_last !== seen_want.last) begin
            flag_mismatch($sformatf("out_last %0b, want %0b", out_last, seen_want.last));
          end
        end
      end
      out_ready <= !take_break();
    end
  end

  // Hang detection: any beat on any channel restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_count <= 0;
      end else if (quiet_count >= QUIET_LIMIT) begin
        $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_count <= quiet_count + 1;
      end
    end
  end

  // Writes one register and mirrors it in the predicted configuration. The leading edge
  // keeps cfg_valid from being lowered and raised in the same step on back-to-back writes.
  task automatic write_reg(input logic [hpe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hpe_pkg::IMG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      hpe_pkg::CFG_IMG_LEN: cur_image  = val;
      hpe_pkg::CFG_PKT_LEN: cur_packet = val[hpe_pkg::PKT_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every byte has been taken and every owed beat has come out. Sampling on
  // the falling edge keeps the decision clear of the updates made at the rising edge.
  task automatic drain();
    do @(negedge clk);
    while (source_bytes.size() != 0 || in_valid || encoded_stream_q.size() != 0);
  endtask

  task automatic queue_random(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      source_bytes.push_back(8'($urandom));
    end
  endtask

  initial begin : stimulus
    int                        i;
    int                        ph;
    logic [hpe_pkg::PKT_W-1:0] ps;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Packets of one codeword put a boundary after every nibble, so the first byte
    // after reset gives the most beats a byte can cause. The upper data bits of a
    // packet size write are ignored by the block.
    write_reg(hpe_pkg::CFG_PKT_LEN, {8'hA5, 16'd1});
    write_reg(hpe_pkg::CFG_IMG_LEN, 24'd600);
    @(negedge clk);
    // Together these bytes carry each of the sixteen nibble values once.
    for (i = 0; i < 8; i++) begin
      source_bytes.push_back({4'(2 * i + 1), 4'(2 * i)});
    end
    source_bytes.push_back(8'h00);
    source_bytes.push_back(8'hFF);
    drain();

    // Largest settings for both registers, and writes to the unmapped indexes that
    // must leave everything unchanged.
    write_reg(hpe_pkg::CFG_PKT_LEN, 24'h00FFFF);
    write_reg(hpe_pkg::CFG_IMG_LEN, 24'hFFFFFF);
    write_reg(CFG_UNMAPPED_LO, 24'($urandom));
    write_reg(CFG_UNMAPPED_HI, 24'($urandom));
    @(negedge clk);
    source_bytes.push_back(8'hFF);
    source_bytes.push_back(8'h00);
    source_bytes.push_back(8'h5A);
    source_bytes.push_back(8'hA5);
    source_bytes.push_back(8'h0F);
    source_bytes.push_back(8'hF0);
    drain();

    // Random phases with short packets, odd and even, so that boundaries land after
    // both the low and the high nibble. The new size stays above the current position
    // here; the wrapping case gets its own phase below. The image stays large enough
    // that the stream cannot end before the final phase.
    for (ph = 0; ph < 6; ph++) begin
      ps = 16'($urandom_range(1, 24));
      if (ps <= st_pos) begin
        ps = st_pos + ps;
      end
      write_reg(hpe_pkg::CFG_PKT_LEN, {8'($urandom), ps});
      write_reg(hpe_pkg::CFG_IMG_LEN, 24'($urandom_range(24'h100000, 24'hFFFFFF)));
      @(negedge clk);
      queue_random(60);
      drain();
    end

    // Packet size shrunk below the current position: the counter would have to wrap
    // all the way round before the packet ends, so these bytes meet no boundary.
    if (st_pos < 16'd2) begin
      write_reg(hpe_pkg::CFG_PKT_LEN, 24'h00FFFF);
      @(negedge clk);
      queue_random(2);
      drain();
    end
    write_reg(hpe_pkg::CFG_PKT_LEN, {8'($urandom), 16'd1});
    @(negedge clk);
    queue_random(8);
    drain();

    // Packet size zero behaves as a packet of 65536 codewords, so again no boundary.
    write_reg(hpe_pkg::CFG_PKT_LEN, {8'($urandom), 16'd0});
    @(negedge clk);
    queue_random(8);
    drain();

    // Final phase: an image size of zero means the next boundary ends the stream. The
    // packet size is chosen so that this boundary follows the low nibble of the next
    // byte, whose high nibble is then dropped. Every byte after that gets one marker.
    write_reg(hpe_pkg::CFG_IMG_LEN, 24'd0);
    write_reg(hpe_pkg::CFG_PKT_LEN, {8'($urandom), st_pos + 16'd1});
    @(negedge clk);
    queue_random(12);
    drain();

    // Give the block time to show any beat it should not produce.
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
